@@ sv/iost_pkg.sv @@
// Types and constants shared by the ordered-set table: request and response
// payloads, operation codes, sequencer states and compare-unit flags.
// No dependencies.
package iost_pkg;

	// Operation codes
	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_ERASE    = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_GET      = 2'd3
	} op_t;

	// Fixed field widths of the payloads
	localparam int unsigned ValueW = 32;
	localparam int unsigned PosW   = 6;
	localparam int unsigned CountW = 7;

	typedef struct packed {
		op_t                 op;
		logic [ValueW-1:0]   item_value;
		logic [PosW-1:0]     position;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [ValueW-1:0]   read_value;
		logic [CountW-1:0]   entry_count;
		logic                is_empty;
		logic                full_refused;
	} rsp_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_CMP   = 7'b0000100,
		S_RES   = 7'b0001000,
		S_SH_RD = 7'b0010000,
		S_SH_WR = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	// Flags from the shared compare unit
	typedef struct packed {
		logic hit;   // entry equals the search value
		logic more;  // index + 1 is still below the count
	} unit_flags_t;

endpackage

@@ sv/iost_unit.sv @@
// Shared compare/increment unit: equality of an entry with the search value,
// next index and the bound check against the count. Uses iost_pkg.
module iost_unit #(
	parameter int unsigned CW = 7,
	parameter int unsigned SW = 32
) (
	input  logic [SW-1:0]         entry,
	input  logic [SW-1:0]         key,
	input  logic [CW-1:0]         idx,
	input  logic [CW-1:0]         cnt,
	output logic [CW-1:0]         nxt,
	output iost_pkg::unit_flags_t flags
);

	// One increment and two compares, reused by scan and shift
	always_comb begin
		nxt        = idx + CW'(1);
		flags.hit  = (entry == key);
		flags.more = (nxt < cnt);
	end

endmodule

@@ sv/iost_mem.sv @@
// Entry storage: one write port, one read port with registered read data.
// No dependencies; contents are undefined until written.
module iost_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned SW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [SW-1:0] rdata
);

	logic [SW-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/insertion_ordered_set_table.sv @@
// Top level of the insertion-ordered set table: sequencer, count and result
// registers around iost_mem and iost_unit. Uses iost_pkg.
//
//  channel | signals                    | direction | payload
//  --------+----------------------------+-----------+---------------------
//  request | req_valid, req_ready, req  | in        | iost_pkg::req_t
//  result  | rsp_valid, rsp_ready, rsp  | out       | iost_pkg::rsp_t
//
// One request at a time; req_ready is high only while the sequencer idles.
// A get beyond the count goes straight to the result; a valid get reads its
// entry; any other request on an empty set goes straight to the result step;
// a search reads and compares one entry at a time until a hit or the count; an
// erase that hits then moves each later entry down one place and closes the gap.
// The single read port of the memory sets one read and one compare per entry.
// Reset clears the count and the control state; entries need no clearing.
// A finished result waits in the output register while the next request is
// taken; the sequencer holds in its last state if that register is still full.
module insertion_ordered_set_table #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  iost_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output iost_pkg::rsp_t   rsp
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned SW   = (VALUE_BITS < iost_pkg::ValueW) ? VALUE_BITS
	                                                                : iost_pkg::ValueW;
	localparam int unsigned CMPW = (CW > iost_pkg::PosW) ? CW : iost_pkg::PosW;

	iost_pkg::state_t      state_q;
	iost_pkg::op_t         op_q;
	logic [SW-1:0]         key_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic                  found_q;
	logic                  ok_q;
	logic [iost_pkg::ValueW-1:0] rdv_q;
	logic                  ref_q;
	logic                  rsp_valid_q;
	iost_pkg::rsp_t        rsp_q;

	logic                  req_xfer;
	logic                  pos_valid;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [SW-1:0]         mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [SW-1:0]         mem_rdata;
	logic [CW-1:0]         nxt;
	iost_pkg::unit_flags_t flags;
	logic                  rsp_load;
	logic [31:0]           cnt_wide;

	assign req_ready = (state_q == iost_pkg::S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign pos_valid = (CMPW'(req.position) < CMPW'(cnt_q));
	assign rsp_load  = (state_q == iost_pkg::S_DONE) && (!rsp_valid_q || rsp_ready);

	// Entry storage
	iost_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.SW    (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared compare/increment unit
	iost_unit #(
		.CW (CW),
		.SW (SW)
	) u_unit (
		.entry (mem_rdata),
		.key   (key_q),
		.idx   (idx_q),
		.cnt   (cnt_q),
		.nxt   (nxt),
		.flags (flags)
	);

	// Read address: requested position, scan index, or the entry after the gap
	always_comb begin
		unique case (state_q)
			iost_pkg::S_IDLE:  mem_raddr = AW'(req.position);
			iost_pkg::S_SH_RD: mem_raddr = nxt[AW-1:0];
			default:           mem_raddr = idx_q[AW-1:0];
		endcase
	end

	// Write port: append on insert, move an entry down during erase
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		if (state_q == iost_pkg::S_SH_WR) begin
			mem_we = 1'b1;
		end else if (state_q == iost_pkg::S_RES && op_q == iost_pkg::OP_INSERT
		             && !found_q && cnt_q != CW'(CAPACITY)) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[AW-1:0];
			mem_wdata = key_q;
		end
	end

	// Sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iost_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				iost_pkg::S_IDLE: begin
					if (req_xfer) begin
						if (req.op == iost_pkg::OP_GET) begin
							state_q <= pos_valid ? iost_pkg::S_CMP : iost_pkg::S_DONE;
						end else begin
							state_q <= (cnt_q == '0) ? iost_pkg::S_RES : iost_pkg::S_RD;
						end
					end
				end
				iost_pkg::S_RD: begin
					state_q <= iost_pkg::S_CMP;
				end
				iost_pkg::S_CMP: begin
					if (op_q == iost_pkg::OP_GET) begin
						state_q <= iost_pkg::S_DONE;
					end else if (flags.hit || !flags.more) begin
						state_q <= iost_pkg::S_RES;
					end else begin
						state_q <= iost_pkg::S_RD;
					end
				end
				iost_pkg::S_RES: begin
					if (op_q == iost_pkg::OP_ERASE && found_q) begin
						state_q <= iost_pkg::S_SH_RD;
					end else begin
						state_q <= iost_pkg::S_DONE;
					end
					if (mem_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				iost_pkg::S_SH_RD: begin
					if (flags.more) begin
						state_q <= iost_pkg::S_SH_WR;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= iost_pkg::S_DONE;
					end
				end
				iost_pkg::S_SH_WR: begin
					state_q <= iost_pkg::S_SH_RD;
				end
				iost_pkg::S_DONE: begin
					if (rsp_load) begin
						state_q <= iost_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= iost_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Request fields, scan index and result fields
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q    <= req.op;
			key_q   <= req.item_value[SW-1:0];
			idx_q   <= '0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			rdv_q   <= '0;
			ref_q   <= 1'b0;
		end
		unique case (state_q)
			iost_pkg::S_CMP: begin
				if (op_q == iost_pkg::OP_GET) begin
					ok_q  <= 1'b1;
					rdv_q <= iost_pkg::ValueW'(mem_rdata);
				end else if (flags.hit) begin
					found_q <= 1'b1;
				end else if (flags.more) begin
					idx_q <= nxt;
				end
			end
			iost_pkg::S_RES: begin
				unique case (op_q)
					iost_pkg::OP_INSERT: begin
						ok_q  <= mem_we;
						ref_q <= !found_q && (cnt_q == CW'(CAPACITY));
					end
					iost_pkg::OP_ERASE:    ok_q <= found_q;
					iost_pkg::OP_CONTAINS: ok_q <= found_q;
					default:               ok_q <= 1'b0;
				endcase
			end
			iost_pkg::S_SH_WR: begin
				idx_q <= nxt;
			end
			default: begin
			end
		endcase
	end

	// Output register
	assign cnt_wide = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.ok           <= ok_q;
			rsp_q.read_value   <= rdv_q;
			rsp_q.entry_count  <= cnt_wide[iost_pkg::CountW-1:0];
			rsp_q.is_empty     <= (cnt_q == '0);
			rsp_q.full_refused <= ref_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
